[rtl/slc_pkg.sv]
package slc_pkg;

   // configuration port geometry
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 9;

   // register indexes
   localparam logic [CSR_INDEX_W-1:0] CSR_BLOCK_SHIFT = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_SET_COUNT   = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_WAY_COUNT   = 2'd2;

   // register reset values
   localparam logic [5:0] BLOCK_SHIFT_RESET = 6'd9;
   localparam logic [8:0] SET_COUNT_RESET   = 9'd64;
   localparam logic [3:0] WAY_COUNT_RESET   = 4'd4;

   // restoring divider runs one step per tag bit
   localparam int TAG_W = 64;

   typedef struct packed {
      logic [63:0] address;
      logic [7:0]  owner_id;
   } req_type;

   typedef struct packed {
      logic        hit;
      logic [2:0]  way_used;
      logic [63:0] miss_total;
   } rsp_type;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_DIVIDE,
      ST_READ,
      ST_SCAN,
      ST_WRITE
   } state_type;

   typedef struct packed {
      logic load;
      logic div_step;
      logic read;
      logic scan_step;
      logic write;
      logic clear_step;
   } cmd_type;

   typedef struct packed {
      logic div_last;
      logic scan_last;
      logic clear_last;
      logic out_free;
   } status_type;

endpackage

[rtl/slc_ctrl.sv]
module slc_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  slc_pkg::status_type status,
   output slc_pkg::cmd_type    cmd
);
   import slc_pkg::*;

   state_type state_ff;
   state_type state_in;

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_CLEAR: begin
            if (status.clear_last) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (req_valid) state_in = ST_DIVIDE;
         end
         ST_DIVIDE: begin
            if (status.div_last) state_in = ST_READ;
         end
         ST_READ: begin
            state_in = ST_SCAN;
         end
         ST_SCAN: begin
            if (status.scan_last) state_in = ST_WRITE;
         end
         ST_WRITE: begin
            if (status.out_free) state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_CLEAR;
         end
      endcase
   end

   // outputs
   always_comb begin
      cmd       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         ST_CLEAR: begin
            cmd.clear_step = 1'b1;
         end
         ST_IDLE: begin
            req_ready = 1'b1;
            cmd.load  = req_valid;
         end
         ST_DIVIDE: begin
            cmd.div_step = 1'b1;
         end
         ST_READ: begin
            cmd.read = 1'b1;
         end
         ST_SCAN: begin
            cmd.scan_step = 1'b1;
         end
         ST_WRITE: begin
            cmd.write = status.out_free;
         end
         default: begin
            cmd = '0;
         end
      endcase
   end

endmodule

[rtl/slc_datapath.sv]
module slc_datapath #(
   parameter int MAX_SETS = 256,
   parameter int MAX_WAYS = 8
) (
   input  logic                               clock,
   input  logic                               reset,
   input  slc_pkg::req_type                   req_data,
   output slc_pkg::rsp_type                   rsp_data,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   input  logic                               csr_we,
   input  logic [slc_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [slc_pkg::CSR_DATA_W-1:0]     csr_wdata,
   input  slc_pkg::cmd_type                   cmd,
   output slc_pkg::status_type                status
);
   import slc_pkg::*;

   localparam int SIW = (MAX_SETS > 1) ? $clog2(MAX_SETS) : 1;
   localparam int SW  = $clog2(MAX_SETS + 1);
   localparam int RW  = SW + 1;
   localparam int WIW = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
   localparam int WCW = $clog2(MAX_WAYS + 1);

   // configuration registers
   logic [5:0] shift_ff;
   logic [8:0] setcnt_ff;
   logic [3:0] waycnt_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         shift_ff  <= BLOCK_SHIFT_RESET;
         setcnt_ff <= SET_COUNT_RESET;
         waycnt_ff <= WAY_COUNT_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_BLOCK_SHIFT: shift_ff  <= csr_wdata[5:0];
            CSR_SET_COUNT:   setcnt_ff <= csr_wdata[8:0];
            CSR_WAY_COUNT:   waycnt_ff <= csr_wdata[3:0];
            default: begin
            end
         endcase
      end
   end

   // sets and ways in use, zero counts as one, large counts saturate
   logic [31:0]    sc32;
   logic [31:0]    wc32;
   logic [SW-1:0]  sets_eff;
   logic [WCW-1:0] ways_eff;
   logic [WCW-1:0] ways_m1;

   always_comb begin
      sc32 = 32'(setcnt_ff);
      wc32 = 32'(waycnt_ff);
      if (sc32 == 32'd0) sets_eff = SW'(1);
      else if (sc32 > 32'(MAX_SETS)) sets_eff = SW'(MAX_SETS);
      else sets_eff = SW'(sc32);
      if (wc32 == 32'd0) ways_eff = WCW'(1);
      else if (wc32 > 32'(MAX_WAYS)) ways_eff = WCW'(MAX_WAYS);
      else ways_eff = WCW'(wc32);
      ways_m1 = ways_eff - WCW'(1);
   end

   // captured word and tag
   logic [7:0]  owner_ff;
   logic [63:0] tag_ff;
   logic [63:0] quo_ff;
   logic [RW-1:0] rem_ff;
   logic [5:0]  div_cnt_ff;
   logic [RW-1:0] rem_try;
   logic [RW-1:0] rem_in;

   // restoring divider step, remainder only
   always_comb begin
      rem_try = {rem_ff[SW-1:0], quo_ff[63]};
      if (rem_try >= {1'b0, sets_eff}) rem_in = rem_try - {1'b0, sets_eff};
      else rem_in = rem_try;
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         owner_ff   <= req_data.owner_id;
         tag_ff     <= req_data.address >> shift_ff;
         quo_ff     <= req_data.address >> shift_ff;
         rem_ff     <= '0;
         div_cnt_ff <= '0;
      end else if (cmd.div_step) begin
         quo_ff     <= {quo_ff[62:0], 1'b0};
         rem_ff     <= rem_in;
         div_cnt_ff <= div_cnt_ff + 6'd1;
      end
   end

   logic [SIW-1:0] set_idx;
   assign set_idx = rem_ff[SIW-1:0];

   // clearing pass counter
   logic [SIW-1:0] clr_cnt_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         clr_cnt_ff <= '0;
      end else if (cmd.clear_step) begin
         clr_cnt_ff <= clr_cnt_ff + SIW'(1);
      end
   end

   // line store, one row per set
   logic [MAX_WAYS-1:0]        mem_valid [MAX_SETS];
   logic [MAX_WAYS-1:0][7:0]   mem_owner [MAX_SETS];
   logic [MAX_WAYS-1:0][63:0]  mem_tag   [MAX_SETS];
   logic [MAX_WAYS-1:0][63:0]  mem_stamp [MAX_SETS];

   logic [MAX_WAYS-1:0]        rd_valid_ff;
   logic [MAX_WAYS-1:0][7:0]   rd_owner_ff;
   logic [MAX_WAYS-1:0][63:0]  rd_tag_ff;
   logic [MAX_WAYS-1:0][63:0]  rd_stamp_ff;

   logic [MAX_WAYS-1:0]        wr_valid;
   logic [MAX_WAYS-1:0][7:0]   wr_owner;
   logic [MAX_WAYS-1:0][63:0]  wr_tag;
   logic [MAX_WAYS-1:0][63:0]  wr_stamp;
   logic [SIW-1:0]             wr_addr;
   logic                       wr_en;

   // scan registers
   logic [WIW-1:0] scan_way_ff;
   logic           found_ff;
   logic [WIW-1:0] hit_way_ff;
   logic [WIW-1:0] best_way_ff;
   logic [63:0]    best_stamp_ff;
   logic [63:0]    access_clock_ff;
   logic [63:0]    miss_ff;
   logic [WIW-1:0] chosen_way;
   logic           cur_match;

   assign chosen_way = found_ff ? hit_way_ff : best_way_ff;

   // new row: touched way takes the stamp, a refill also takes valid, owner and tag; a clearing step zeroes the row
   always_comb begin
      wr_valid = rd_valid_ff;
      wr_owner = rd_owner_ff;
      wr_tag   = rd_tag_ff;
      wr_stamp = rd_stamp_ff;
      for (int w = 0; w < MAX_WAYS; w++) begin
         if (WIW'(w) == chosen_way) begin
            wr_stamp[w] = access_clock_ff;
            if (!found_ff) begin
               wr_valid[w] = 1'b1;
               wr_owner[w] = owner_ff;
               wr_tag[w]   = tag_ff;
            end
         end
      end
      if (cmd.clear_step) begin
         wr_valid = '0;
         wr_owner = '0;
         wr_tag   = '0;
         wr_stamp = '0;
      end
      wr_addr = cmd.clear_step ? clr_cnt_ff : set_idx;
      wr_en   = cmd.clear_step | cmd.write;
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_valid[wr_addr] <= wr_valid;
         mem_owner[wr_addr] <= wr_owner;
         mem_tag[wr_addr]   <= wr_tag;
         mem_stamp[wr_addr] <= wr_stamp;
      end
      if (cmd.read) begin
         rd_valid_ff <= mem_valid[set_idx];
         rd_owner_ff <= mem_owner[set_idx];
         rd_tag_ff   <= mem_tag[set_idx];
         rd_stamp_ff <= mem_stamp[set_idx];
      end
   end

   // way scan, one way a cycle: first match and oldest stamp
   assign cur_match = rd_valid_ff[scan_way_ff] && (rd_owner_ff[scan_way_ff] == owner_ff)
                      && (rd_tag_ff[scan_way_ff] == tag_ff);

   always_ff @(posedge clock) begin
      if (cmd.read) begin
         scan_way_ff <= '0;
         found_ff    <= 1'b0;
      end else if (cmd.scan_step) begin
         scan_way_ff <= scan_way_ff + WIW'(1);
         if (!found_ff && cur_match) begin
            found_ff   <= 1'b1;
            hit_way_ff <= scan_way_ff;
         end
         if (scan_way_ff == '0 || rd_stamp_ff[scan_way_ff] < best_stamp_ff) begin
            best_stamp_ff <= rd_stamp_ff[scan_way_ff];
            best_way_ff   <= scan_way_ff;
         end
      end
   end

   // counters and result register
   logic [31:0] way32;
   assign way32 = 32'(chosen_way);

   logic rsp_valid_ff;
   rsp_type rsp_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         access_clock_ff <= '0;
         miss_ff         <= '0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         if (cmd.write) begin
            access_clock_ff <= access_clock_ff + 64'd1;
            if (!found_ff) miss_ff <= miss_ff + 64'd1;
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.write) begin
         rsp_ff.hit        <= found_ff;
         rsp_ff.way_used   <= way32[2:0];
         rsp_ff.miss_total <= found_ff ? miss_ff : miss_ff + 64'd1;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // status back to the controller
   always_comb begin
      status.div_last   = (div_cnt_ff == 6'd63);
      status.scan_last  = (32'(scan_way_ff) == 32'(ways_m1));
      status.clear_last = (32'(clr_cnt_ff) == 32'(MAX_SETS - 1));
      status.out_free   = !rsp_valid_ff || rsp_ready;
   end

endmodule

[rtl/set_assoc_lru_cache_model.sv]
// channel  direction  handshake              word
// req      in         req_valid / req_ready  address, owner_id
// rsp      out        rsp_valid / rsp_ready  hit, way_used, miss_total
// csr      in         csr_we (no wait)       csr_index, csr_wdata
//
// from acceptance to result an access runs the serial remainder unit for the set,
// one store read, a scan of the ways in use, one way per cycle, and one write-back.
// after reset a clearing pass sweeps every set of the store, with req_ready low.
// a result waiting in the output register holds the write-back until taken,
// and req_ready stays low until the write-back is done.
module set_assoc_lru_cache_model #(
   parameter int MAX_SETS = 256,
   parameter int MAX_WAYS = 8
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  slc_pkg::req_type                req_data,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output slc_pkg::rsp_type                rsp_data,
   input  logic                            csr_we,
   input  logic [slc_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [slc_pkg::CSR_DATA_W-1:0]  csr_wdata
);
   import slc_pkg::*;

   cmd_type    cmd;
   status_type status;

   // sequencer
   slc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   // store, remainder unit and counters
   slc_datapath #(
      .MAX_SETS (MAX_SETS),
      .MAX_WAYS (MAX_WAYS)
   ) u_dp (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .rsp_data  (rsp_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cmd       (cmd),
      .status    (status)
   );

endmodule

[rtl/slc_checker.sv]
module slc_assertions (
   input logic             clock,
   input logic             reset,
   input logic             req_valid,
   input logic             req_ready,
   input slc_pkg::rsp_type rsp_data,
   input logic             rsp_valid,
   input logic             rsp_ready
);
   import slc_pkg::*;

   // nothing offered or taken straight after reset
   a_reset: assert property (@(posedge clock) reset |=> !req_ready && !rsp_valid)
      else $error("ready or valid high after reset");

   // one access at a time
   a_single: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("second word accepted while busy");

   // a new result only comes out of a busy period
   a_result: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(!req_ready))
      else $error("result appeared without an access in flight");

   // a stalled result holds
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("stalled result changed");

   // a miss has been counted
   a_miss: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.hit |-> rsp_data.miss_total != 64'd0)
      else $error("miss reported with zero miss total");

endmodule

bind set_assoc_lru_cache_model slc_assertions u_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_ready (req_ready),
   .rsp_data  (rsp_data),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready)
);

[test/slc_checker.sv]
module slc_checker
   import slc_pkg::*;
#(
   parameter int MAX_SETS = 256,
   parameter int MAX_WAYS = 8
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   input  logic                    req_ready,
   input  req_type                 req_data,
   input  logic                    rsp_valid,
   input  logic                    rsp_ready,
   input  rsp_type                 rsp_data,
   input  logic                    csr_we,
   input  logic [CSR_INDEX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0]   csr_wdata,
   output int                      error_count,
   output int                      pending_count
);

   localparam int LINES = MAX_SETS * MAX_WAYS;

   // shadow of the registers and of the cache store
   logic [5:0]  shift_reg;
   logic [8:0]  sets_reg;
   logic [3:0]  ways_reg;
   logic        line_ok   [LINES];
   logic [7:0]  line_pid  [LINES];
   logic [63:0] line_tag  [LINES];
   logic [63:0] line_age  [LINES];
   logic [63:0] lru_clock;
   logic [63:0] misses;

   rsp_type expected_words[$];

   // lookup and lru refill of one access, updating the shadow store
   function automatic rsp_type lookup_and_refill(input logic [63:0] address,
                                                 input logic [7:0] owner);
      logic [63:0] tag;
      int          sets;
      int          ways;
      int          base;
      int          way;
      logic        found;
      logic [63:0] oldest;
      rsp_type     r;
      tag   = address >> shift_reg;
      sets  = (sets_reg == 0) ? 1 : (sets_reg > MAX_SETS) ? MAX_SETS : int'(sets_reg);
      ways  = (ways_reg == 0) ? 1 : (ways_reg > MAX_WAYS) ? MAX_WAYS : int'(ways_reg);
      base  = int'(tag % 64'(sets)) * MAX_WAYS;
      way   = 0;
      found = 1'b0;
      for (int w = 0; w < ways; w++) begin
         if (!found && line_ok[base+w] && line_pid[base+w] == owner &&
             line_tag[base+w] == tag) begin
            found = 1'b1;
            way   = w;
         end
      end
      if (!found) begin
         oldest = line_age[base];
         for (int w = 1; w < ways; w++) begin
            if (line_age[base+w] < oldest) begin
               oldest = line_age[base+w];
               way    = w;
            end
         end
         line_ok[base+way]  = 1'b1;
         line_pid[base+way] = owner;
         line_tag[base+way] = tag;
         misses             = misses + 64'd1;
      end
      line_age[base+way] = lru_clock;
      lru_clock          = lru_clock + 64'd1;
      r.hit        = found;
      r.way_used   = 3'(way);
      r.miss_total = misses;
      return r;
   endfunction

   // watch the channels, predict on accepted requests, compare on accepted responses
   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         shift_reg = BLOCK_SHIFT_RESET;
         sets_reg  = SET_COUNT_RESET;
         ways_reg  = WAY_COUNT_RESET;
         for (int i = 0; i < LINES; i++) begin
            line_ok[i]  = 1'b0;
            line_pid[i] = '0;
            line_tag[i] = '0;
            line_age[i] = '0;
         end
         lru_clock = '0;
         misses    = '0;
         expected_words.delete();
         error_count   <= 0;
         pending_count <= 0;
      end else begin
         if (csr_we) begin
            case (csr_index)
               CSR_BLOCK_SHIFT: shift_reg = csr_wdata[5:0];
               CSR_SET_COUNT:   sets_reg  = csr_wdata[8:0];
               CSR_WAY_COUNT:   ways_reg  = csr_wdata[3:0];
               default: ;
            endcase
         end
         if (req_valid && req_ready)
            expected_words.push_back(lookup_and_refill(req_data.address, req_data.owner_id));
         if (rsp_valid && rsp_ready) begin
            if (expected_words.size() == 0) begin
               if (error_count < 10)
                  $display("unexpected rsp word: hit=%0d way=%0d misses=%0d",
                           rsp_data.hit, rsp_data.way_used, rsp_data.miss_total);
               error_count <= error_count + 1;
            end else begin
               want = expected_words.pop_front();
               if (want !== rsp_data) begin
                  if (error_count < 10)
                     $display("rsp mismatch: expected hit=%0d way=%0d misses=%0d, got hit=%0d way=%0d misses=%0d",
                              want.hit, want.way_used, want.miss_total,
                              rsp_data.hit, rsp_data.way_used, rsp_data.miss_total);
                  error_count <= error_count + 1;
               end
            end
         end
         pending_count <= expected_words.size();
      end
   end

endmodule

[test/set_assoc_lru_cache_model_tb.sv]
module set_assoc_lru_cache_model_tb;
   import slc_pkg::*;

   localparam int MAX_SETS = 256;
   localparam int MAX_WAYS = 8;
   localparam int CYCLE_LIMIT = 1000000;
   localparam int DRAIN_CYCLES = 100;

   logic                   clock;
   logic                   reset;
   logic                   req_valid;
   logic                   req_ready;
   req_type                req_data;
   logic                   rsp_valid;
   logic                   rsp_ready;
   rsp_type                rsp_data;
   logic                   csr_we;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0]  csr_wdata;
   int                     error_count;
   int                     pending_count;
   int                     cycle_count = 0;
   int                     rsp_stall;
   logic                   burst_mode;
   logic [63:0]            addr_pool[16];
   logic [7:0]             owner_pool[4];

   set_assoc_lru_cache_model #(.MAX_SETS(MAX_SETS), .MAX_WAYS(MAX_WAYS)) DUT (.*);

   slc_checker #(.MAX_SETS(MAX_SETS), .MAX_WAYS(MAX_WAYS)) checker_inst (.*);

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // run limit
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("Some tests failed");
         $finish;
      end
   end

   // result side: random stall before each word, none in burst stretches
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
         rsp_stall <= 0;
      end else if (rsp_valid && rsp_ready) begin
         rsp_stall <= burst_mode ? 0 : $urandom_range(0, 16);
         rsp_ready <= burst_mode;
      end else if (rsp_stall > 0) begin
         rsp_stall <= rsp_stall - 1;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   // send one word, idling a random gap first; valid stays high across back-to-back words
   task automatic send_word(input logic [63:0] address, input logic [7:0] owner);
      int gap;
      gap = burst_mode ? 0 : $urandom_range(0, 16);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid         <= 1'b1;
      req_data.address  <= address;
      req_data.owner_id <= owner;
      do @(posedge clock); while (!req_ready);
   endtask

   // register write, only while idle
   task automatic write_csr(input logic [CSR_INDEX_W-1:0] index,
                            input logic [CSR_DATA_W-1:0] value);
      csr_we    <= 1'b1;
      csr_index <= index;
      csr_wdata <= value;
      @(posedge clock);
      csr_we    <= 1'b0;
      @(posedge clock);
   endtask

   task automatic drain;
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // mostly reuse of a small pool of blocks and owners, some fully random words
   task automatic random_phase(input int count);
      logic [63:0] address;
      logic [7:0]  owner;
      for (int i = 0; i < 16; i++) addr_pool[i] = {$urandom, $urandom};
      for (int i = 0; i < 4; i++) owner_pool[i] = 8'($urandom);
      for (int n = 0; n < count; n++) begin
         if (n % 40 == 0) burst_mode = ($urandom_range(0, 3) == 0);
         if ($urandom_range(0, 9) < 7) begin
            address = addr_pool[$urandom_range(0, 15)] ^ 64'($urandom_range(0, 7));
            owner   = owner_pool[$urandom_range(0, 3)];
         end else begin
            address = {$urandom, $urandom};
            owner   = 8'($urandom);
         end
         send_word(address, owner);
      end
      burst_mode = 1'b0;
      drain();
   endtask

   initial begin
      logic [63:0] stride;
      reset      <= 1'b1;
      req_valid  <= 1'b0;
      req_data   <= '0;
      csr_we     <= 1'b0;
      csr_index  <= CSR_BLOCK_SHIFT;
      csr_wdata  <= '0;
      burst_mode = 1'b0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: field extremes, repeat hits, owner mismatch, eviction in one set
      stride = 64'd64 << 9;
      send_word(64'd0, 8'd0);
      send_word(64'd0, 8'd0);
      send_word(64'd0, 8'd255);
      send_word('1, 8'd255);
      send_word('1, 8'd255);
      send_word(64'h5555_5555_5555_5555, 8'h55);
      send_word(64'hAAAA_AAAA_AAAA_AAAA, 8'hAA);
      for (int k = 1; k <= 6; k++) send_word(stride * k, 8'd1);
      send_word(stride * 2, 8'd1);
      send_word(stride * 1, 8'd1);
      send_word(64'd0, 8'd0);
      drain();

      // set and way counts at and beyond their limits, shifts at both ends
      write_csr(CSR_BLOCK_SHIFT, 9'd0);
      write_csr(CSR_SET_COUNT, 9'd0);
      write_csr(CSR_WAY_COUNT, 9'd0);
      for (int k = 0; k < 4; k++) send_word(64'(k), 8'd7);
      send_word(64'd2, 8'd7);
      drain();
      write_csr(CSR_BLOCK_SHIFT, 9'd63);
      write_csr(CSR_SET_COUNT, 9'd511);
      write_csr(CSR_WAY_COUNT, 9'd15);
      send_word('1, 8'd3);
      send_word(64'h7FFF_FFFF_FFFF_FFFF, 8'd3);
      send_word('1, 8'd3);
      drain();

      // random phases across settings
      write_csr(CSR_BLOCK_SHIFT, 9'd9);
      write_csr(CSR_SET_COUNT, 9'd64);
      write_csr(CSR_WAY_COUNT, 9'd4);
      random_phase(150);
      write_csr(CSR_BLOCK_SHIFT, 9'd0);
      write_csr(CSR_SET_COUNT, 9'd1);
      write_csr(CSR_WAY_COUNT, 9'd8);
      random_phase(150);
      write_csr(CSR_BLOCK_SHIFT, 9'd63);
      write_csr(CSR_SET_COUNT, 9'd256);
      write_csr(CSR_WAY_COUNT, 9'd1);
      random_phase(100);
      write_csr(CSR_BLOCK_SHIFT, 9'd3);
      write_csr(CSR_SET_COUNT, 9'd3);
      write_csr(CSR_WAY_COUNT, 9'd2);
      random_phase(150);
      for (int p = 0; p < 4; p++) begin
         write_csr(CSR_BLOCK_SHIFT, 9'($urandom_range(0, 63)));
         write_csr(CSR_SET_COUNT, 9'($urandom_range(0, 511)));
         write_csr(CSR_WAY_COUNT, 9'($urandom_range(0, 15)));
         random_phase(90);
      end

      if (error_count == 0 && pending_count == 0)
         $display("All tests passed");
      else
         $display("Some tests failed");
      $finish;
   end

endmodule
